@@ rtl/fspa_pkg.sv @@
// Shared types, constants and helper functions of the fixed-slot pool allocator.
package fspa_pkg;

	// Pool geometry.
	localparam int MaxSlots = 1024;
	localparam int SlotW    = $clog2(MaxSlots);
	localparam int CntW     = SlotW + 1;
	localparam int AddrW    = 48;
	localparam int SizeW    = 17;
	// A 17-bit object size rounds up to as much as 2^17 bytes, so the slot size takes one more bit.
	localparam int StrideW  = SizeW + 1;
	localparam int ProdW    = CntW + SizeW;
	localparam int DataW    = 64;
	localparam int PaddrW   = 5;

	// Slot size rounding: round up to a multiple of eight bytes.
	localparam logic [StrideW-1:0] SizeRound = StrideW'(7);
	localparam logic [StrideW-1:0] SizeMask  = ~SizeRound;

	// Register indexes on the configuration port.
	localparam logic [1:0] RegBase  = 2'd0;
	localparam logic [1:0] RegSize  = 2'd1;
	localparam logic [1:0] RegSlots = 2'd2;

	// Operation codes.
	localparam logic FuncAlloc = 1'b0;
	localparam logic FuncFree  = 1'b1;

	// Result status codes.
	typedef logic [1:0] status_t;
	localparam status_t StatOk        = 2'd0;
	localparam status_t StatExhausted = 2'd1;
	localparam status_t StatRange     = 2'd2;
	localparam status_t StatOverflow  = 2'd3;

	// Number of slots in the pool for a given slot_count register value.
	function automatic logic [CntW-1:0] pool_slots(input logic [CntW-1:0] sc);
		logic [CntW-1:0] n;
		n = sc;
		if (sc == '0) begin
			n = CntW'(1);
		end else if (sc > CntW'(MaxSlots)) begin
			n = CntW'(MaxSlots);
		end
		return n;
	endfunction

	// Slot size in bytes: object size (zero taken as one) rounded up to eight.
	function automatic logic [StrideW-1:0] slot_bytes(input logic [SizeW-1:0] os);
		logic [StrideW-1:0] s;
		s = (os == '0) ? StrideW'(1) : StrideW'(os);
		return (s + SizeRound) & SizeMask;
	endfunction

endpackage

@@ rtl/fspa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module fspa_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/fixed_slot_pool_allocator_core.sv @@
// Top level of the fixed-slot pool allocator: register port, sequencer and datapath.
//
// The block hands out and takes back equal-sized slots from a pool described by
// three registers (base_address at byte 0, object_size at byte 8, slot_count at
// byte 16, 64-bit APB data). Free slot indices live on a LIFO stack in a
// 1024-entry RAM; slot 0 is on top after reset or after a slot_count write.
// Entries never written since the last refill are supplied from a watermark,
// so no clearing pass is needed and the block is ready right out of reset.
// One transaction is worked on at a time: an allocate goes through the stack
// RAM read, the slot select, one slot-times-size multiply and the base add; an
// exhausted allocate goes to the result after the top-of-stack check, and a free
// runs the range checks, the ten-step restoring divider that reuses one 28-bit
// subtract-and-compare each cycle, and the push; a pointer out of range returns
// after the base check or the bound check. A finished result waits in the output
// register while the next transaction is accepted.
module fixed_slot_pool_allocator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fspa_pkg::PaddrW-1:0]         paddr,
	input  logic [fspa_pkg::DataW-1:0]          pwdata,
	output logic [fspa_pkg::DataW-1:0]          prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic [fspa_pkg::AddrW-1:0]          pointer,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fspa_pkg::AddrW-1:0]          address,
	output logic [fspa_pkg::SlotW-1:0]          slot,
	output fspa_pkg::status_t                   status,
	output logic [fspa_pkg::CntW-1:0]           used_count,
	output logic [fspa_pkg::CntW-1:0]           available_count
);
	import fspa_pkg::*;

	// Sequencer states.
	localparam logic [3:0] SIdle     = 4'd0;
	localparam logic [3:0] SAllocRd  = 4'd1;
	localparam logic [3:0] SAllocSel = 4'd2;
	localparam logic [3:0] SAllocMul = 4'd3;
	localparam logic [3:0] SAllocAdd = 4'd4;
	localparam logic [3:0] SFreeChk  = 4'd5;
	localparam logic [3:0] SFreeCmp  = 4'd6;
	localparam logic [3:0] SFreeDiv  = 4'd7;
	localparam logic [3:0] SFreePush = 4'd8;
	localparam logic [3:0] SDone     = 4'd9;

	localparam int DivSteps = SlotW;
	localparam int DivW     = StrideW + SlotW - 1;
	localparam int StepW    = $clog2(DivSteps);

	// Configuration registers.
	logic [AddrW-1:0] base_q;
	logic [SizeW-1:0] objsize_q;
	logic [CntW-1:0]  slotcnt_q;

	// Stack and sequencer state.
	logic [3:0]       state_q;
	logic [CntW-1:0]  top_q;
	logic [CntW-1:0]  used_q;
	logic [CntW-1:0]  dirty_q;

	// Working registers.
	logic [AddrW-1:0] ptr_q;
	logic [AddrW-1:0] offset_q;
	logic [ProdW-1:0] prod_q;
	logic [ProdW-1:0] rem_q;
	logic [DivW-1:0]  div_q;
	logic [SlotW-1:0] quo_q;
	logic [StepW-1:0] step_q;
	logic [SlotW-1:0] wslot_q;
	logic [AddrW-1:0] res_addr_q;
	logic [SlotW-1:0] res_slot_q;
	status_t          res_status_q;

	// Output register.
	logic             out_valid_q;
	logic [AddrW-1:0] address_q;
	logic [SlotW-1:0] slot_q;
	status_t          status_q;
	logic [CntW-1:0]  used_count_q;
	logic [CntW-1:0]  avail_count_q;

	logic               cfg_wr;
	logic [1:0]         cfg_idx;
	logic [CntW-1:0]    pool_n;
	logic [CntW-1:0]    wr_pool_n;
	logic [StrideW-1:0] size;
	logic               in_acc;
	logic               out_free;
	logic [CntW-1:0]    pop_idx;
	logic [SlotW-1:0]   ram_rdata;
	logic               ram_we;
	logic [CntW-1:0]    mul_a;
	logic [ProdW-1:0]   mul_p;
	logic               div_ge;

	// Register port decode.
	assign cfg_wr    = psel & penable & pwrite & pready;
	assign cfg_idx   = paddr[PaddrW-1:3];
	assign pready    = 1'b1;
	assign wr_pool_n = pool_slots(pwdata[CntW-1:0]);

	always_comb begin
		case (cfg_idx)
			RegBase:  prdata = DataW'(base_q);
			RegSize:  prdata = DataW'(objsize_q);
			RegSlots: prdata = DataW'(slotcnt_q);
			default:  prdata = '0;
		endcase
	end

	// Derived pool geometry.
	assign pool_n = pool_slots(slotcnt_q);
	assign size   = slot_bytes(objsize_q);

	// Handshakes.
	assign in_stall = (state_q != SIdle);
	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	// Free stack RAM: read below the top for a pop, write at the top for a push.
	assign pop_idx = top_q - CntW'(1);
	assign ram_we  = (state_q == SFreePush) && (top_q < pool_n);

	fspa_ram #(
		.Width(SlotW),
		.Depth(MaxSlots)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(top_q[SlotW-1:0]),
		.wdata(quo_q),
		.raddr(pop_idx[SlotW-1:0]),
		.rdata(ram_rdata)
	);

	// Shared multiplier: slot times size for an allocate, pool size for a free.
	assign mul_a = (state_q == SAllocMul) ? CntW'(wslot_q) : pool_n;
	assign mul_p = ProdW'(mul_a) * ProdW'(size);

	// Shared subtract-and-compare of the divider.
	assign div_ge = (rem_q >= ProdW'(div_q));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			objsize_q <= SizeW'(8);
			slotcnt_q <= CntW'(MaxSlots);
		end else if (cfg_wr) begin
			case (cfg_idx)
				RegBase:  base_q    <= pwdata[AddrW-1:0];
				RegSize:  objsize_q <= pwdata[SizeW-1:0];
				RegSlots: slotcnt_q <= pwdata[CntW-1:0];
				default:  ;
			endcase
		end
	end

	// Sequencer and stack bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SIdle;
			top_q   <= CntW'(MaxSlots);
			used_q  <= '0;
			dirty_q <= CntW'(MaxSlots);
			step_q  <= '0;
		end else begin
			case (state_q)
				SIdle: begin
					if (in_acc) begin
						state_q <= (func == FuncFree) ? SFreeChk : SAllocRd;
					end
				end
				SAllocRd: begin
					state_q <= (top_q == '0) ? SDone : SAllocSel;
				end
				SAllocSel: state_q <= SAllocMul;
				SAllocMul: state_q <= SAllocAdd;
				SAllocAdd: begin
					top_q   <= pop_idx;
					used_q  <= used_q + CntW'(1);
					state_q <= SDone;
				end
				SFreeChk: begin
					state_q <= (ptr_q < base_q) ? SDone : SFreeCmp;
				end
				SFreeCmp: begin
					step_q  <= StepW'(DivSteps - 1);
					state_q <= (offset_q >= AddrW'(prod_q)) ? SDone : SFreeDiv;
				end
				SFreeDiv: begin
					step_q <= step_q - StepW'(1);
					if (step_q == '0) begin
						state_q <= SFreePush;
					end
				end
				SFreePush: begin
					if (top_q < pool_n) begin
						top_q <= top_q + CntW'(1);
						if (top_q < dirty_q) begin
							dirty_q <= top_q;
						end
						if (used_q != '0) begin
							used_q <= used_q - CntW'(1);
						end
					end
					state_q <= SDone;
				end
				SDone: begin
					if (out_free) begin
						state_q <= SIdle;
					end
				end
				default: state_q <= SIdle;
			endcase
			// A slot_count write refills the stack; the user must write it only while idle, the block does not enforce this.
			if (cfg_wr && cfg_idx == RegSlots) begin
				top_q   <= wr_pool_n;
				dirty_q <= wr_pool_n;
				used_q  <= '0;
			end
		end
	end

	// Datapath registers of the transaction in flight.
	always_ff @(posedge clk) begin
		case (state_q)
			SIdle: begin
				ptr_q        <= pointer;
				res_addr_q   <= '0;
				res_slot_q   <= '0;
				res_status_q <= StatOk;
			end
			SAllocRd: begin
				if (top_q == '0) begin
					res_status_q <= StatExhausted;
				end
			end
			SAllocSel: begin
				// Entries below the watermark still hold their refill value.
				if (pop_idx < dirty_q) begin
					wslot_q <= SlotW'(pool_n - CntW'(1) - pop_idx);
				end else begin
					wslot_q <= ram_rdata;
				end
			end
			SAllocMul: prod_q <= mul_p;
			SAllocAdd: begin
				res_addr_q <= base_q + AddrW'(prod_q);
				res_slot_q <= wslot_q;
			end
			SFreeChk: begin
				offset_q <= ptr_q - base_q;
				prod_q   <= mul_p;
				if (ptr_q < base_q) begin
					res_status_q <= StatRange;
				end
			end
			SFreeCmp: begin
				rem_q <= offset_q[ProdW-1:0];
				div_q <= {size, (SlotW-1)'(0)};
				quo_q <= '0;
				if (offset_q >= AddrW'(prod_q)) begin
					res_status_q <= StatRange;
				end
			end
			SFreeDiv: begin
				// One restoring step: subtract the shifted divisor when it fits.
				if (div_ge) begin
					rem_q <= rem_q - ProdW'(div_q);
				end
				quo_q <= {quo_q[SlotW-2:0], div_ge};
				div_q <= div_q >> 1;
			end
			SFreePush: begin
				res_slot_q <= quo_q;
				if (top_q >= pool_n) begin
					res_status_q <= StatOverflow;
				end
			end
			default: ;
		endcase
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == SDone && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (state_q == SDone && out_free) begin
			address_q     <= res_addr_q;
			slot_q        <= res_slot_q;
			status_q      <= res_status_q;
			used_count_q  <= used_q;
			avail_count_q <= top_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign address         = address_q;
	assign slot            = slot_q;
	assign status          = status_q;
	assign used_count      = used_count_q;
	assign available_count = avail_count_q;

endmodule

@@ dv/fixed_slot_pool_allocator_core_tb.sv @@
// Self-checking testbench for the fixed-slot pool allocator core.
module fixed_slot_pool_allocator_core_tb;
	import fspa_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int NumDir     = 32;
	localparam int NumPhases  = 8;
	localparam int PhaseItems = 250;
	localparam int DrainWait  = 20;

	// One result transaction as the block reports it.
	typedef struct packed {
		logic [AddrW-1:0] address;
		logic [SlotW-1:0] slot;
		status_t          status;
		logic [CntW-1:0]  used;
		logic [CntW-1:0]  avail;
	} pool_result_t;

	// One row of the directed table: either a register write or a transaction.
	typedef struct packed {
		bit               is_cfg;
		logic [1:0]       reg_idx;
		logic [DataW-1:0] value;
		logic             f;
		logic [AddrW-1:0] p;
		bit               typed;
		pool_result_t     res;
	} dir_row_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [PaddrW-1:0]   paddr     = '0;
	logic [DataW-1:0]    pwdata    = '0;
	logic [DataW-1:0]    prdata;
	logic                pready;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic                func      = FuncAlloc;
	logic [AddrW-1:0]    pointer   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [AddrW-1:0]    address;
	logic [SlotW-1:0]    slot;
	status_t             status;
	logic [CntW-1:0]     used_count;
	logic [CntW-1:0]     available_count;

	fixed_slot_pool_allocator_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.pointer         (pointer),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.address         (address),
		.slot            (slot),
		.status          (status),
		.used_count      (used_count),
		.available_count (available_count)
	);

	// Shadow copy of the pool configuration and free stack.
	logic [AddrW-1:0] pool_base;
	logic [SizeW-1:0] pool_obj_size;
	logic [CntW-1:0]  pool_slot_reg;
	logic [SlotW-1:0] free_slot_stack [MaxSlots];
	int unsigned      stack_depth;
	int unsigned      used_slots;

	pool_result_t     pending_results [$];
	logic [SlotW-1:0] held_slots [$];
	int               error_count = 0;
	int               items_sent = 0;
	int               results_checked = 0;
	int               status_seen [4] = '{0, 0, 0, 0};
	int               cycle_count = 0;

	// Receiver stall pattern state.
	int               stall_mode = 0;
	int               stall_left = 0;

	dir_row_t         dir_rows [NumDir];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Slots actually in the pool: zero counts as one, large values saturate.
	function automatic int unsigned active_slots();
		if (pool_slot_reg == '0) begin
			return 1;
		end
		return (pool_slot_reg > MaxSlots) ? MaxSlots : pool_slot_reg;
	endfunction

	// Bytes per slot: object size (zero counts as one) rounded up to eight.
	function automatic logic [63:0] slot_stride();
		logic [63:0] s;
		s = (pool_obj_size == '0) ? 64'd1 : 64'(pool_obj_size);
		return (s + 64'd7) & ~64'd7;
	endfunction

	// Refill the free stack with every slot, slot zero on top.
	function automatic void refill_pool();
		int unsigned n;
		n = active_slots();
		for (int unsigned i = 0; i < n; i++) begin
			free_slot_stack[i] = SlotW'(n - 1 - i);
		end
		stack_depth = n;
		used_slots = 0;
	endfunction

	// Work out the result of one transaction and advance the shadow state.
	function automatic pool_result_t predict_pool_op(input logic f, input logic [AddrW-1:0] p);
		pool_result_t r;
		logic [63:0]  stride;
		logic [63:0]  quot;
		int unsigned  n;
		r = '0;
		n = active_slots();
		stride = slot_stride();
		if (f == FuncAlloc) begin
			if (stack_depth == 0) begin
				r.status = StatExhausted;
			end else begin
				stack_depth--;
				r.slot = free_slot_stack[stack_depth];
				used_slots++;
				r.address = AddrW'(64'(pool_base) + 64'(r.slot) * stride);
				r.status = StatOk;
			end
		end else if (p < pool_base) begin
			r.status = StatRange;
		end else begin
			quot = (64'(p) - 64'(pool_base)) / stride;
			if (quot >= 64'(n)) begin
				r.status = StatRange;
			end else if (stack_depth >= n) begin
				r.status = StatOverflow;
				r.slot = quot[SlotW-1:0];
			end else begin
				r.status = StatOk;
				r.slot = quot[SlotW-1:0];
				free_slot_stack[stack_depth] = quot[SlotW-1:0];
				stack_depth++;
				if (used_slots > 0) begin
					used_slots--;
				end
			end
		end
		r.used = used_slots[CntW-1:0];
		r.avail = stack_depth[CntW-1:0];
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [DataW-1:0] v);
		dir_row_t d;
		d = '0;
		d.is_cfg = 1'b1;
		d.reg_idx = idx;
		d.value = v;
		return d;
	endfunction

	function automatic dir_row_t op_row(input logic f, input logic [AddrW-1:0] p);
		dir_row_t d;
		d = '0;
		d.f = f;
		d.p = p;
		return d;
	endfunction

	function automatic dir_row_t op_exp(input logic f, input logic [AddrW-1:0] p,
			input logic [AddrW-1:0] a, input logic [SlotW-1:0] s, input status_t st,
			input logic [CntW-1:0] u, input logic [CntW-1:0] av);
		dir_row_t d;
		d = op_row(f, p);
		d.typed = 1'b1;
		d.res = '{address: a, slot: s, status: st, used: u, avail: av};
		return d;
	endfunction

	// Register write through the configuration port; shadow state follows.
	task automatic write_reg(input logic [1:0] idx, input logic [DataW-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			RegBase: pool_base = v[AddrW-1:0];
			RegSize: pool_obj_size = v[SizeW-1:0];
			RegSlots: begin
				pool_slot_reg = v[CntW-1:0];
				refill_pool();
				held_slots.delete();
			end
			default: ;
		endcase
		// Leave the port idle before the next register write.
		@(posedge clk);
	endtask

	// Present one transaction, hold it until accepted, then queue its expectation.
	task automatic send_item(input logic f, input logic [AddrW-1:0] p, input bit typed,
			input pool_result_t typed_res);
		pool_result_t r;
		in_valid <= 1'b1;
		func <= f;
		pointer <= p;
		do @(posedge clk); while (in_stall);
		r = predict_pool_op(f, p);
		pending_results.push_back(typed ? typed_res : r);
		items_sent++;
		// Keep a list of live slots so that most frees are well formed.
		if (r.status == StatOk && f == FuncAlloc) begin
			held_slots.push_back(r.slot);
		end else if (r.status == StatOk) begin
			for (int i = 0; i < held_slots.size(); i++) begin
				if (held_slots[i] == r.slot) begin
					held_slots.delete(i);
					break;
				end
			end
		end
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			error_count++;
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
		end
	endtask

	// Receiver stall pattern: free-running, light, heavy and periodic stretches.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(30, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= stall_left[2];
		endcase
	end

	// Compare every accepted result transaction with the oldest expectation.
	always @(posedge clk) begin : result_check
		pool_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$error("result transaction arrived with no expectation pending");
			end else begin
				want = pending_results.pop_front();
				check_field("address", 64'(want.address), 64'(address));
				check_field("slot", 64'(want.slot), 64'(slot));
				check_field("status", 64'(want.status), 64'(status));
				check_field("used_count", 64'(want.used), 64'(used_count));
				check_field("available_count", 64'(want.avail), 64'(available_count));
				results_checked++;
				status_seen[want.status]++;
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int               burst_left;
		int               gap;
		int               alloc_pct;
		int               pick;
		int unsigned      n;
		logic [63:0]      stride;
		logic [63:0]      k;
		logic             f;
		logic [AddrW-1:0] p;
		logic [AddrW-1:0] new_base;
		logic [SizeW-1:0] new_size;
		logic [CntW-1:0]  new_slots;

		pool_base = '0;
		pool_obj_size = SizeW'(8);
		pool_slot_reg = CntW'(MaxSlots);
		refill_pool();

		// Directed table: reset state, extremes, wrap and every special case.
		dir_rows = '{
			op_exp(FuncAlloc, 48'h0, 48'h0, 10'd0, StatOk, 11'd1, 11'd1023),
			op_exp(FuncAlloc, 48'hFFFF_FFFF_FFFF, 48'h8, 10'd1, StatOk, 11'd2, 11'd1022),
			op_exp(FuncFree, 48'h8, 48'h0, 10'd1, StatOk, 11'd1, 11'd1023),
			op_exp(FuncFree, 48'h0, 48'h0, 10'd0, StatOk, 11'd0, 11'd1024),
			op_exp(FuncFree, 48'hD, 48'h0, 10'd1, StatOverflow, 11'd0, 11'd1024),
			op_exp(FuncFree, 48'h2000, 48'h0, 10'd0, StatRange, 11'd0, 11'd1024),
			op_exp(FuncFree, 48'hFFFF_FFFF_FFFF, 48'h0, 10'd0, StatRange, 11'd0, 11'd1024),
			op_row(FuncAlloc, 48'h0),
			cfg_row(RegBase, 64'hFFFF_FFFF_FFFF_FFF8),
			cfg_row(RegSize, 64'd0),
			cfg_row(RegSlots, 64'd2),
			op_exp(FuncAlloc, 48'h0, 48'hFFFF_FFFF_FFF8, 10'd0, StatOk, 11'd1, 11'd1),
			op_exp(FuncAlloc, 48'h0, 48'h0, 10'd1, StatOk, 11'd2, 11'd0),
			op_exp(FuncAlloc, 48'h0, 48'h0, 10'd0, StatExhausted, 11'd2, 11'd0),
			op_exp(FuncFree, 48'h0, 48'h0, 10'd0, StatRange, 11'd2, 11'd0),
			op_exp(FuncFree, 48'hFFFF_FFFF_FFFF, 48'h0, 10'd0, StatOk, 11'd1, 11'd1),
			op_row(FuncFree, 48'hFFFF_FFFF_FFF8),
			op_row(FuncFree, 48'hFFFF_FFFF_FFFF),
			cfg_row(RegBase, 64'd0),
			cfg_row(RegSize, 64'd65536),
			cfg_row(RegSlots, 64'd0),
			op_exp(FuncAlloc, 48'h0, 48'h0, 10'd0, StatOk, 11'd1, 11'd0),
			op_exp(FuncAlloc, 48'h0, 48'h0, 10'd0, StatExhausted, 11'd1, 11'd0),
			op_exp(FuncFree, 48'h10000, 48'h0, 10'd0, StatRange, 11'd1, 11'd0),
			op_exp(FuncFree, 48'hFFFF, 48'h0, 10'd0, StatOk, 11'd0, 11'd1),
			cfg_row(RegBase, 64'h100),
			cfg_row(RegSize, 64'd1),
			cfg_row(RegSlots, 64'd2047),
			op_exp(FuncFree, 48'hFF, 48'h0, 10'd0, StatRange, 11'd0, 11'd1024),
			op_row(FuncAlloc, 48'h0),
			op_row(FuncFree, 48'h100 + 48'd1023 * 48'd8 + 48'd7),
			op_row(FuncFree, 48'h100 + 48'd1024 * 48'd8)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				wait_drained();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
			end else begin
				send_item(dir_rows[i].f, dir_rows[i].p, dir_rows[i].typed, dir_rows[i].res);
			end
		end

		// Random part: one pool setting per phase, bursts of transactions in between.
		burst_left = 0;
		for (int ph = 0; ph < NumPhases; ph++) begin
			wait_drained();
			case ($urandom_range(0, 3))
				0: new_base = '0;
				1: new_base = 48'hFFFF_FFFF_FFFF - AddrW'($urandom_range(0, 4096));
				2: new_base = AddrW'({$urandom, $urandom});
				default: new_base = AddrW'({$urandom_range(0, 255), 12'h000});
			endcase
			case ($urandom_range(0, 3))
				0: new_size = '0;
				1: new_size = SizeW'(65536);
				2: new_size = SizeW'($urandom_range(1, 64));
				default: new_size = SizeW'($urandom_range(1, 65536));
			endcase
			if (ph == 0) begin
				new_slots = CntW'(MaxSlots);
			end else if (ph == 1) begin
				new_slots = CntW'(2047);
			end else if (ph == 2) begin
				new_slots = CntW'(1);
			end else begin
				case ($urandom_range(0, 3))
					0: new_slots = '0;
					1: new_slots = CntW'($urandom_range(2, 8));
					2: new_slots = CntW'($urandom_range(9, 64));
					default: new_slots = CntW'($urandom_range(65, 1100));
				endcase
			end
			write_reg(RegBase, 64'(new_base));
			write_reg(RegSize, 64'(new_size));
			write_reg(RegSlots, 64'(new_slots));

			for (int j = 0; j < PhaseItems; j++) begin
				// Now and then hold off until the pool has answered everything.
				if ($urandom_range(0, 39) == 0) begin
					wait_drained();
				end else if (burst_left == 0) begin
					gap = $urandom_range(0, 6);
					if (gap > 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					burst_left = $urandom_range(1, 20);
				end
				burst_left--;

				// Alternate between filling and draining the pool.
				alloc_pct = ((j / 32) % 2 == 0) ? 75 : 25;
				n = active_slots();
				stride = slot_stride();
				f = ($urandom_range(0, 99) < alloc_pct) ? FuncAlloc : FuncFree;
				p = AddrW'({$urandom, $urandom});
				if (f == FuncFree) begin
					pick = $urandom_range(0, 99);
					if (pick < 70) begin
						if (held_slots.size() != 0 && $urandom_range(0, 3) != 0) begin
							k = 64'(held_slots[$urandom_range(0, held_slots.size() - 1)]);
						end else begin
							k = 64'($urandom_range(0, n - 1));
						end
						p = AddrW'(64'(pool_base) + k * stride
							+ 64'($urandom_range(0, 32'(stride) - 1)));
					end else if (pick < 80) begin
						k = 64'(n + $urandom_range(0, 3));
						p = AddrW'(64'(pool_base) + k * stride);
					end else if (pick < 88 && pool_base != '0) begin
						p = pool_base - AddrW'(1) - AddrW'(64'({$urandom, $urandom}) % 64'(pool_base));
					end
				end
				send_item(f, p, 1'b0, '0);
			end
		end

		wait_drained();
		$display("Checked %0d results from %0d transactions over %0d random pool settings.",
			results_checked, items_sent, NumPhases);
		$display("Status mix: ok %0d, exhausted %0d, out of range %0d, stack overflow %0d.",
			status_seen[StatOk], status_seen[StatExhausted], status_seen[StatRange],
			status_seen[StatOverflow]);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/fspa_pkg.sv
rtl/fspa_ram.sv
rtl/fixed_slot_pool_allocator_core.sv
dv/fixed_slot_pool_allocator_core_tb.sv
